@@ hdl/wsmd_pkg.sv @@
`default_nettype none
package wsmd_pkg;

  localparam int SUM_W = 36;
  localparam int DIV_STEPS = 4;
  localparam int DIV_CYCLES = SUM_W / DIV_STEPS;
  localparam int DIV_CNT_W = $clog2(DIV_CYCLES);

  localparam logic [2:0] KIND_SAMPLE = 3'd0;
  localparam logic [2:0] KIND_DONE = 3'd1;
  localparam logic [2:0] KIND_NOT_RIFF = 3'd2;
  localparam logic [2:0] KIND_MISSING = 3'd3;
  localparam logic [2:0] KIND_BAD_FORMAT = 3'd4;
  localparam logic [2:0] KIND_BAD_BITS = 3'd5;

  typedef struct packed {
    logic step;
    logic acc;
    logic div_load;
    logic div_run;
    logic wr_sample;
    logic wr_status;
    logic clr;
  } cmd_t;

  typedef struct packed {
    logic smp_now;
    logic frame_full;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

@@ hdl/wsmd_ctrl.sv @@
`default_nettype none
module wsmd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          end_of_file,
  output logic               in_stall,
  input  wsmd_pkg::sts_t     sts,
  output wsmd_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_DIVL,
    S_DIV,
    S_EMIT_S,
    S_EMIT_E
  } state_t;

  state_t state;
  state_t state_next;
  logic [wsmd_pkg::DIV_CNT_W-1:0] cnt;
  logic eof_pend;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.step = 1'b1;
          if (sts.smp_now) begin
            state_next = S_ACC;
          end else if (end_of_file) begin
            state_next = S_EMIT_E;
          end
        end
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (sts.frame_full) begin
          state_next = S_DIVL;
        end else if (eof_pend) begin
          state_next = S_EMIT_E;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIVL: begin
        cmd.div_load = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_run = 1'b1;
        if (cnt == wsmd_pkg::DIV_CNT_W'(wsmd_pkg::DIV_CYCLES - 1)) begin
          state_next = S_EMIT_S;
        end
      end
      S_EMIT_S: begin
        if (sts.out_free) begin
          cmd.wr_sample = 1'b1;
          state_next = eof_pend ? S_EMIT_E : S_IDLE;
        end
      end
      S_EMIT_E: begin
        if (sts.out_free) begin
          cmd.wr_status = 1'b1;
          cmd.clr = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      eof_pend <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.step) begin
        eof_pend <= end_of_file;
      end else if (cmd.wr_status) begin
        eof_pend <= 1'b0;
      end
      if (cmd.div_load) begin
        cnt <= '0;
      end else if (cmd.div_run) begin
        cnt <= (cnt == wsmd_pkg::DIV_CNT_W'(wsmd_pkg::DIV_CYCLES - 1)) ? '0 : cnt + 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_wr_in_emit: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_sample || cmd.wr_status) |-> (state == S_EMIT_S || state == S_EMIT_E))
    else $error("result written outside an emit state");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt < wsmd_pkg::DIV_CNT_W'(wsmd_pkg::DIV_CYCLES))
    else $error("divide counter out of range");
  a_div_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && cnt == wsmd_pkg::DIV_CNT_W'(wsmd_pkg::DIV_CYCLES - 1))
    |=> state == S_EMIT_S)
    else $error("divide did not hand over to sample emit");
`endif

endmodule
`default_nettype wire

@@ hdl/wsmd_dp.sv @@
`default_nettype none
module wsmd_dp #(
  parameter int MAX_CHANNELS = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [7:0]    file_byte,
  input  wsmd_pkg::cmd_t     cmd,
  output wsmd_pkg::sts_t     sts,
  input  wire logic          out_stall,
  output logic               out_valid,
  output logic [2:0]         kind,
  output logic signed [31:0] mono_sample,
  output logic [31:0]        rate_hz,
  output logic               final_res
);

  typedef enum logic [3:0] {
    PH_RIFF, PH_SIZE, PH_WAVE, PH_HDR, PH_FMT, PH_DATA, PH_SKIP, PH_PAD, PH_BAD
  } phase_t;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam int SW = wsmd_pkg::SUM_W;

  phase_t phase, phase_next;
  logic [31:0] bc, bc_next, bc_inc;
  logic [31:0] tag, tag_next, len, len_next, rate, rate_next, gather, gather_next;
  logic [15:0] fmt, fmt_next, chans, chans_next, bits, bits_next;
  logic [1:0] seen, seen_next, lane, lane_next, lane_last;
  logic [4:0] chidx, chidx_next;
  logic signed [SW-1:0] sum, sum_next;
  logic [SW-1:0] dvd, dvd_next;
  logic [3:0] rem, rem_next;
  logic neg, neg_next;
  logic fmt_ok, bits_ok, decodable;
  logic signed [31:0] conv;
  logic [2:0] kind_e;

  assign bc_inc = bc + 32'd1;
  assign fmt_ok = (fmt == 16'd1 || fmt == 16'd3) && (chans <= 16'(MAX_CHANNELS));
  assign bits_ok = (bits == 16'd16 || bits == 16'd24 || bits == 16'd32);
  assign decodable = fmt_ok && bits_ok && (chans != 16'd0);
  assign lane_last = (bits == 16'd16) ? 2'd1 : ((bits == 16'd24) ? 2'd2 : 2'd3);

  assign sts.smp_now = (phase == PH_DATA) && (lane == lane_last);
  assign sts.frame_full = ({11'd0, chidx + 5'd1} == chans);
  assign sts.out_free = !out_valid || !out_stall;

  // Float32 to Q1.31 with saturation; integer words are already left aligned.
  always_comb begin
    logic [7:0] e;
    logic [23:0] man;
    logic [31:0] mag;
    logic [7:0] rsh;
    e = gather[30:23];
    man = {1'b1, gather[22:0]};
    mag = '0;
    rsh = 8'd119 - e;
    if (fmt == 16'd3 && bits == 16'd32) begin
      if (e == 8'hFF && gather[22:0] != 23'd0) begin
        conv = '0;
      end else if (e >= 8'd127) begin
        conv = gather[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else if (e == 8'd0) begin
        conv = '0;
      end else begin
        if (e >= 8'd119) begin
          mag = {8'd0, man} << (e - 8'd119);
        end else if (rsh < 8'd24) begin
          mag = {8'd0, man} >> rsh;
        end
        conv = gather[31] ? -signed'(mag) : signed'(mag);
      end
    end else begin
      conv = signed'(gather);
    end
  end

  always_comb begin
    logic [4:0] r;
    logic [SW-1:0] dv;
    logic [3:0] rm;
    phase_next = phase; bc_next = bc; tag_next = tag; len_next = len;
    fmt_next = fmt; chans_next = chans; rate_next = rate; bits_next = bits;
    seen_next = seen; gather_next = gather; lane_next = lane; chidx_next = chidx;
    sum_next = sum; dvd_next = dvd; rem_next = rem; neg_next = neg;
    r = '0; dv = dvd; rm = rem;
    if (cmd.step) begin
      case (phase)
        PH_RIFF, PH_WAVE: begin
          tag_next = {file_byte, tag[31:8]};
          bc_next = bc_inc;
          if (bc_inc == 32'd4) begin
            bc_next = '0;
            if (phase == PH_RIFF) begin
              phase_next = (tag_next == TAG_RIFF) ? PH_SIZE : PH_BAD;
            end else begin
              phase_next = (tag_next == TAG_WAVE) ? PH_HDR : PH_BAD;
            end
          end
        end
        PH_SIZE: begin
          bc_next = bc_inc;
          if (bc_inc == 32'd4) begin
            bc_next = '0;
            phase_next = PH_WAVE;
          end
        end
        PH_HDR: begin
          if (bc < 32'd4) begin
            tag_next = {file_byte, tag[31:8]};
          end else begin
            len_next = {file_byte, len[31:8]};
          end
          bc_next = bc_inc;
          if (bc_inc == 32'd8) begin
            bc_next = '0;
            if (tag_next == TAG_FMT) begin
              fmt_next = '0; chans_next = '0; rate_next = '0; bits_next = '0;
              phase_next = PH_FMT;
              if (len_next == 32'd0) begin
                seen_next[0] = 1'b1;
                phase_next = PH_HDR;
              end
            end else begin
              phase_next = PH_SKIP;
              if (tag_next == TAG_DATA && seen[0]) begin
                seen_next[1] = 1'b1;
                if (decodable) begin
                  phase_next = PH_DATA;
                  gather_next = '0; chidx_next = '0; sum_next = '0; lane_next = '0;
                end
              end
              if (len_next == 32'd0) begin
                phase_next = PH_HDR;
              end
            end
          end
        end
        PH_FMT: begin
          case (bc) inside
            32'd0: fmt_next = {8'd0, file_byte};
            32'd1: fmt_next = {file_byte, fmt[7:0]};
            32'd2: chans_next = {8'd0, file_byte};
            32'd3: chans_next = {file_byte, chans[7:0]};
            [32'd4:32'd7]: begin
              case (bc[1:0])
                2'd0: rate_next = rate | {24'd0, file_byte};
                2'd1: rate_next = rate | {16'd0, file_byte, 8'd0};
                2'd2: rate_next = rate | {8'd0, file_byte, 16'd0};
                default: rate_next = rate | {file_byte, 24'd0};
              endcase
            end
            32'd14: bits_next = {8'd0, file_byte};
            32'd15: bits_next = {file_byte, bits[7:0]};
            32'd24: begin
              if (fmt == 16'hFFFE && len >= 32'd40) tag_next = {24'd0, file_byte};
            end
            32'd25: begin
              if (fmt == 16'hFFFE && len >= 32'd40) fmt_next = {file_byte, tag[7:0]};
            end
            default: begin
            end
          endcase
          bc_next = bc_inc;
          if (bc_inc == len) begin
            seen_next[0] = 1'b1;
            bc_next = '0;
            phase_next = len[0] ? PH_PAD : PH_HDR;
          end
        end
        PH_DATA: begin
          gather_next = {file_byte, gather[31:8]};
          lane_next = sts.smp_now ? 2'd0 : lane + 2'd1;
          bc_next = bc_inc;
          if (bc_inc == len) begin
            bc_next = '0;
            phase_next = len[0] ? PH_PAD : PH_HDR;
          end
        end
        PH_SKIP: begin
          bc_next = bc_inc;
          if (bc_inc == len) begin
            bc_next = '0;
            phase_next = len[0] ? PH_PAD : PH_HDR;
          end
        end
        PH_PAD: begin
          bc_next = '0;
          phase_next = PH_HDR;
        end
        default: phase_next = PH_BAD;
      endcase
    end else if (cmd.acc) begin
      sum_next = sum + SW'(conv);
      gather_next = '0;
      chidx_next = chidx + 5'd1;
    end else if (cmd.div_load) begin
      neg_next = sum[SW-1];
      dvd_next = sum[SW-1] ? unsigned'(-sum) : unsigned'(sum);
      rem_next = '0;
      sum_next = '0;
      chidx_next = '0;
    end else if (cmd.div_run) begin
      for (int i = 0; i < wsmd_pkg::DIV_STEPS; i++) begin
        r = {rm, dv[SW-1]};
        dv = {dv[SW-2:0], 1'b0};
        if (r >= chans[4:0]) begin
          r = r - chans[4:0];
          dv[0] = 1'b1;
        end
        rm = r[3:0];
      end
      dvd_next = dv;
      rem_next = rm;
    end
  end

  always_comb begin
    if (phase == PH_RIFF || phase == PH_SIZE || phase == PH_WAVE || phase == PH_BAD) begin
      kind_e = wsmd_pkg::KIND_NOT_RIFF;
    end else if (seen != 2'b11) begin
      kind_e = wsmd_pkg::KIND_MISSING;
    end else if (!fmt_ok) begin
      kind_e = wsmd_pkg::KIND_BAD_FORMAT;
    end else if (!bits_ok) begin
      kind_e = wsmd_pkg::KIND_BAD_BITS;
    end else begin
      kind_e = wsmd_pkg::KIND_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      phase <= PH_RIFF; bc <= '0; tag <= '0; len <= '0;
      fmt <= '0; chans <= '0; rate <= '0; bits <= '0;
      seen <= '0; gather <= '0; lane <= '0; chidx <= '0; sum <= '0;
    end else begin
      phase <= phase_next; bc <= bc_next; tag <= tag_next; len <= len_next;
      fmt <= fmt_next; chans <= chans_next; rate <= rate_next; bits <= bits_next;
      seen <= seen_next; gather <= gather_next; lane <= lane_next; chidx <= chidx_next;
      sum <= sum_next;
    end
    dvd <= dvd_next;
    rem <= rem_next;
    neg <= neg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.wr_sample || cmd.wr_status) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.wr_sample) begin
      kind <= wsmd_pkg::KIND_SAMPLE;
      mono_sample <= neg ? -signed'(dvd[31:0]) : signed'(dvd[31:0]);
      rate_hz <= rate;
      final_res <= 1'b0;
    end else if (cmd.wr_status) begin
      kind <= kind_e;
      mono_sample <= '0;
      rate_hz <= rate;
      final_res <= 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ hdl/wav_stream_mono_decoder_unit.sv @@
`default_nettype none
// Streaming RIFF/WAVE decoder that takes one file byte per item and returns one
// mono Q1.31 sample per complete data frame, plus a status item (final_res set)
// after the byte marked end_of_file; the fmt chunk must come before the data
// chunk. A byte that completes no sample does not stall the input, and the next
// one can be taken on the following cycle. A byte that completes a channel
// sample holds the input for the float conversion and accumulation, and a byte
// that completes a frame adds the channel divide: a load state and a radix-16
// restoring divider, then the load of the output register, so the input is held
// until that result is written. The end byte adds a state for the status item.
// Each result waits in an output register, so a stalled consumer only holds the
// block when a new result is ready to be written.
module wav_stream_mono_decoder_unit #(
  parameter int MAX_CHANNELS = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    file_byte,
  input  wire logic          end_of_file,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [2:0]         kind,
  output logic signed [31:0] mono_sample,
  output logic [31:0]        rate_hz,
  output logic               final_res
);

  // Commands from the sequencer and status back from the parser/datapath.
  wsmd_pkg::cmd_t cmd;
  wsmd_pkg::sts_t sts;

  wsmd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .end_of_file (end_of_file),
    .in_stall    (in_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  wsmd_dp #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .file_byte   (file_byte),
    .cmd         (cmd),
    .sts         (sts),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .kind        (kind),
    .mono_sample (mono_sample),
    .rate_hz     (rate_hz),
    .final_res   (final_res)
  );

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
module testbench;

  // One predicted or observed result item of the decoder.
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] sample;
    logic [31:0] rate;
    logic        fin;
  } wav_result_t;

  // Parse phases of the predictor, mirroring the decoder's walk through the file.
  typedef enum logic [3:0] {
    P_RIFF, P_SIZE, P_WAVE, P_HDR, P_FMT, P_DATA, P_SKIP, P_PAD, P_BAD
  } wav_phase_t;

  localparam logic [31:0] ID_RIFF = 32'h46464952;
  localparam logic [31:0] ID_WAVE = 32'h45564157;
  localparam logic [31:0] ID_FMT  = 32'h20746D66;
  localparam logic [31:0] ID_DATA = 32'h61746164;
  localparam int          CHAN_MAX = 8;
  localparam logic [15:0] FMT_PCM = 16'd1;
  localparam logic [15:0] FMT_FLOAT = 16'd3;
  localparam logic [15:0] FMT_EXT = 16'hFFFE;

  // The scoreboard keeps its own copy of the decoder state and a queue of
  // results still owed by the block.
  class wav_decode_board;
    wav_phase_t  phase;
    logic [31:0] pos, shreg, clen, rate;
    logic [15:0] fmtc, chans, bits;
    logic [1:0]  seen;
    logic [31:0] gather;
    logic [4:0]  cidx;
    longint      fsum;
    wav_result_t owed[$];
    int          errors;

    function void clear_state();
      phase = P_RIFF; pos = '0; shreg = '0; clen = '0; rate = '0;
      fmtc = '0; chans = '0; bits = '0; seen = '0; gather = '0; cidx = '0; fsum = 0;
    endfunction

    function bit fmt_good();
      return (fmtc == FMT_PCM || fmtc == FMT_FLOAT) && chans <= CHAN_MAX;
    endfunction

    function bit bits_good();
      return bits == 16 || bits == 24 || bits == 32;
    endfunction

    // Float32 to Q1.31 with saturation; NaN gives zero, denormals give zero.
    function longint float_q31(logic [31:0] w);
      logic [7:0] e;
      logic [22:0] f;
      longint mag;
      int sh;
      e = w[30:23];
      f = w[22:0];
      if (e == 8'hFF && f != 0) return 0;
      if (e >= 127) return w[31] ? -64'sd2147483648 : 64'sd2147483647;
      if (e == 0) return 0;
      sh = int'(e) - 119;
      if (sh >= 0) mag = longint'({1'b1, f}) << sh;
      else if (sh > -24) mag = longint'({1'b1, f}) >> (-sh);
      else mag = 0;
      return w[31] ? -mag : mag;
    endfunction

    function void close_body();
      pos = '0;
      phase = clen[0] ? P_PAD : P_HDR;
    endfunction

    function void open_body();
      if (shreg == ID_FMT) begin
        fmtc = '0; chans = '0; rate = '0; bits = '0;
        phase = P_FMT;
        if (clen == 0) begin
          seen[0] = 1'b1;
          close_body();
        end
        return;
      end
      phase = P_SKIP;
      if (shreg == ID_DATA && seen[0]) begin
        seen[1] = 1'b1;
        if (fmt_good() && bits_good() && chans != 0) begin
          phase = P_DATA;
          gather = '0; cidx = '0; fsum = 0;
        end
      end
      if (clen == 0) close_body();
    endfunction

    function void push(logic [2:0] k, logic [31:0] s, logic fin);
      wav_result_t r;
      r.kind = k; r.sample = s; r.rate = rate; r.fin = fin;
      owed.push_back(r);
    endfunction

    // Note one accepted byte and queue the results it causes.
    function void note_byte(logic [7:0] b, logic eof);
      logic [31:0] bps;
      longint s;
      logic [2:0] k;
      case (phase)
        P_RIFF, P_WAVE: begin
          shreg = {b, shreg[31:8]};
          pos++;
          if (pos == 4) begin
            pos = '0;
            if (phase == P_RIFF) phase = (shreg == ID_RIFF) ? P_SIZE : P_BAD;
            else phase = (shreg == ID_WAVE) ? P_HDR : P_BAD;
          end
        end
        P_SIZE: begin
          pos++;
          if (pos == 4) begin
            pos = '0;
            phase = P_WAVE;
          end
        end
        P_HDR: begin
          if (pos < 4) shreg = {b, shreg[31:8]};
          else clen = {b, clen[31:8]};
          pos++;
          if (pos == 8) begin
            pos = '0;
            open_body();
          end
        end
        P_FMT: begin
          case (pos)
            0: fmtc[7:0] = b;
            1: fmtc[15:8] = b;
            2: chans[7:0] = b;
            3: chans[15:8] = b;
            4, 5, 6, 7: rate[8*(pos-4) +: 8] = b;
            14: bits[7:0] = b;
            15: bits[15:8] = b;
            24, 25: if (fmtc == FMT_EXT && clen >= 40) begin
              if (pos == 24) shreg = {24'd0, b};
              else fmtc = {b, shreg[7:0]};
            end
            default: ;
          endcase
          pos++;
          if (pos == clen) begin
            seen[0] = 1'b1;
            close_body();
          end
        end
        P_DATA: begin
          bps = {16'd0, bits} / 32'd8;
          gather = {b, gather[31:8]};
          if (bps != 0 && pos % bps == bps - 1) begin
            if (fmtc == FMT_FLOAT && bits == 32) s = float_q31(gather);
            else s = longint'(signed'(gather));
            fsum += s;
            gather = '0;
            cidx = cidx + 5'd1;
            if (cidx == chans) begin
              s = fsum / longint'(chans);
              push(wsmd_pkg::KIND_SAMPLE, s[31:0], 1'b0);
              cidx = '0; fsum = 0;
            end
          end
          pos++;
          if (pos == clen) close_body();
        end
        P_SKIP: begin
          pos++;
          if (pos == clen) close_body();
        end
        P_PAD: begin
          pos = '0;
          phase = P_HDR;
        end
        default: phase = P_BAD;
      endcase
      if (eof) begin
        if (phase <= P_WAVE || phase == P_BAD) k = wsmd_pkg::KIND_NOT_RIFF;
        else if (seen != 2'b11) k = wsmd_pkg::KIND_MISSING;
        else if (!fmt_good()) k = wsmd_pkg::KIND_BAD_FORMAT;
        else if (!bits_good()) k = wsmd_pkg::KIND_BAD_BITS;
        else k = wsmd_pkg::KIND_DONE;
        push(k, 32'd0, 1'b1);
        clear_state();
      end
    endfunction

    // Compare one accepted result with the oldest expectation, field by field.
    function void check_result(logic [2:0] k, logic [31:0] s, logic [31:0] r, logic fin);
      wav_result_t e;
      if (owed.size() == 0) begin
        $error("unexpected result kind=%0d sample=%h", k, s);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (k !== e.kind) begin
        $error("kind: expected %0d, got %0d", e.kind, k);
        errors++;
      end
      if (s !== e.sample) begin
        $error("mono_sample: expected %h, got %h", e.sample, s);
        errors++;
      end
      if (r !== e.rate) begin
        $error("rate_hz: expected %h, got %h", e.rate, r);
        errors++;
      end
      if (fin !== e.fin) begin
        $error("final_res: expected %0d, got %0d", e.fin, fin);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  file_byte = 8'd0;
  logic        end_of_file = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [2:0]  kind;
  logic signed [31:0] mono_sample;
  logic [31:0] rate_hz;
  logic        final_res;

  wav_decode_board board;
  logic [7:0]  wav_bytes[$];   // bytes of the file being built
  int          byte_total;
  bit          feed_calm;      // no idling on either side when set
  bit          calm_done;
  bit          hold_out;       // long receiver hold-off in progress
  bit          hold_done;
  bit          feed_done;

  wav_stream_mono_decoder_unit #(.MAX_CHANNELS(CHAN_MAX)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .file_byte(file_byte), .end_of_file(end_of_file),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .mono_sample(mono_sample), .rate_hz(rate_hz), .final_res(final_res)
  );

  always #2 clk = ~clk;

  // Little-endian helpers for building files.
  task automatic put32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) wav_bytes.push_back(v[8*i +: 8]);
  endtask

  task automatic put16(input logic [15:0] v);
    wav_bytes.push_back(v[7:0]);
    wav_bytes.push_back(v[15:8]);
  endtask

  // Appends a fmt chunk; an extensible header carries the real format at body
  // offset 24. A short length truncates the body.
  task automatic put_fmt(input logic [15:0] fc, input logic [15:0] ch,
                         input logic [31:0] rt, input logic [15:0] bt,
                         input logic [15:0] subfc, input int blen);
    logic [7:0] body[40];
    for (int i = 0; i < 40; i++) body[i] = 8'($urandom_range(0, 255));
    {body[1], body[0]} = fc;
    {body[3], body[2]} = ch;
    {body[7], body[6], body[5], body[4]} = rt;
    {body[15], body[14]} = bt;
    {body[25], body[24]} = subfc;
    put32(ID_FMT);
    put32(32'(blen));
    for (int i = 0; i < blen; i++)
      wav_bytes.push_back(i < 40 ? body[i] : 8'($urandom_range(0, 255)));
    if (blen % 2) wav_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Appends a chunk with the given id and a random body; odd sizes get a pad.
  task automatic put_chunk(input logic [31:0] id, input int blen);
    logic [31:0] w;
    put32(id);
    put32(32'(blen));
    for (int i = 0; i < blen; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        // A random word, of which only the low byte is written.
        w = $urandom();
        wav_bytes.push_back(w[7:0]);
      end else wav_bytes.push_back(8'($urandom_range(0, 255)));
    end
    if (blen % 2) wav_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  // Appends a data chunk of whole float frames covering the special values.
  task automatic put_float_data(input int ch, input int frames);
    logic [31:0] w;
    put32(ID_DATA);
    put32(32'(ch * frames * 4));
    for (int i = 0; i < ch * frames; i++) begin
      case ($urandom_range(0, 7))
        0: w = {$urandom_range(0, 1) == 1, 8'hFF, 23'd0};          // infinity
        1: w = {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(1, 100))};
        2: w = {$urandom_range(0, 1) == 1, 8'd127, 23'($urandom())};
        3: w = {$urandom_range(0, 1) == 1, 8'd0, 23'($urandom())};
        4: w = {$urandom_range(0, 1) == 1, 8'($urandom_range(90, 126)), 23'($urandom())};
        default: w = $urandom();
      endcase
      put32(w);
    end
  endtask

  // Builds one random file, mostly well formed, sometimes broken.
  task automatic build_file();
    int ch, bt, fc, frames;
    wav_bytes.delete();
    case ($urandom_range(0, 19))
      0: begin
        // Bad RIFF tag or an early end.
        for (int i = 0; i < $urandom_range(1, 14); i++)
          wav_bytes.push_back(8'($urandom_range(0, 255)));
        return;
      end
      1: begin
        put32(ID_RIFF); put32($urandom()); put32($urandom_range(0, 1) ? ID_WAVE : 32'h45564156);
        put_chunk(ID_DATA, $urandom_range(0, 5));
        return;
      end
      default: ;
    endcase
    put32(ID_RIFF);
    put32($urandom());
    put32(ID_WAVE);
    if ($urandom_range(0, 3) == 0) put_chunk($urandom(), $urandom_range(0, 7));
    ch = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 4);
    bt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : 8 * $urandom_range(2, 4);
    fc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5) : $urandom_range(0, 1) ? 1 : 3;
    if ($urandom_range(0, 5) == 0)
      put_fmt(FMT_EXT, 16'(ch), $urandom(), 16'(bt), 16'(fc), $urandom_range(0, 1) ? 40 : 41);
    else if ($urandom_range(0, 9) == 0)
      put_fmt(16'(fc), 16'(ch), $urandom(), 16'(bt), 16'd0, $urandom_range(0, 20));
    else
      put_fmt(16'(fc), 16'(ch), $urandom(), 16'(bt), 16'd0, 16);
    frames = $urandom_range(1, 6);
    if (fc == 3 && bt == 32 && ch >= 1 && ch <= 4 && $urandom_range(0, 1))
      put_float_data(ch, frames);
    else
      put_chunk(ID_DATA, ch * (bt / 8) * frames + (($urandom_range(0, 4) == 0) ? 1 : 0));
    if ($urandom_range(0, 4) == 0) put_chunk($urandom(), $urandom_range(0, 3));
    if ($urandom_range(0, 9) == 0) wav_bytes = wav_bytes[0:$urandom_range(0, wav_bytes.size() - 1)];
  endtask

  // Offers one byte and waits until the block takes it.
  task automatic send_byte(input logic [7:0] b, input logic eof);
    if (!feed_calm && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (!feed_calm && $urandom_range(0, 99) < 25) @(posedge clk);
    end
    in_valid <= 1'b1;
    file_byte <= b;
    end_of_file <= eof;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_byte(b, eof);
    byte_total++;
  endtask

  task automatic send_file();
    for (int i = 0; i < wav_bytes.size(); i++)
      send_byte(wav_bytes[i], i == wav_bytes.size() - 1);
  endtask

  // Receiver: stalls at random, except during calm stretches; one long
  // hold-off lets the block back up into its input.
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b1;
    else if (hold_out) out_stall <= 1'b1;
    else if (feed_calm) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < 25);
  end

  // Results are checked at the edge where they are accepted.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_result(kind, mono_sample, rate_hz, final_res);
  end

  initial begin
    board = new();
    board.clear_state();
    board.errors = 0;
    byte_total = 0;
    feed_calm = 1'b0;
    calm_done = 1'b0;
    hold_out = 1'b0;
    hold_done = 1'b0;
    feed_done = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed files: 16-bit stereo extremes, extensible float mono, bad tag.
    wav_bytes.delete();
    put32(ID_RIFF); put32(32'd0); put32(ID_WAVE);
    put_fmt(FMT_PCM, 16'd2, 32'hFFFFFFFF, 16'd16, 16'd0, 16);
    put32(ID_DATA); put32(32'd8);
    put16(16'h7FFF); put16(16'h7FFF); put16(16'h8000); put16(16'h0001);
    send_file();
    wav_bytes.delete();
    put32(ID_RIFF); put32(32'd0); put32(ID_WAVE);
    put_fmt(FMT_EXT, 16'd1, 32'd48000, 16'd32, FMT_FLOAT, 40);
    put32(ID_DATA); put32(32'd12);
    put32(32'h3F800000); put32(32'hFF800000); put32(32'h7FC00000);
    send_file();
    wav_bytes = '{8'h52, 8'h49, 8'h46, 8'h00};
    send_file();

    // Random files, with one calm stretch and one long hold-off.
    while (byte_total < 600) begin
      build_file();
      feed_calm = (byte_total > 250 && !calm_done);
      if (!hold_done && byte_total > 400) begin
        hold_done = 1'b1;
        fork
          begin
            hold_out = 1'b1;
            repeat (300) @(posedge clk);
            hold_out = 1'b0;
          end
          send_file();
        join
      end else send_file();
      if (feed_calm && byte_total > 350) calm_done = 1'b1;
    end
    in_valid <= 1'b0;
    feed_calm = 1'b0;
    feed_done = 1'b1;
  end

  initial begin
    wait (feed_done);
    while (board.owed.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.errors == 0 && board.owed.size() == 0)
      $display("** wav_stream_mono_decoder_unit: PASSED **");
    else
      $display("** wav_stream_mono_decoder_unit: FAILED **");
    $finish;
  end

  initial begin
    #2000000;
    $display("** wav_stream_mono_decoder_unit: FAILED **");
    $finish;
  end
endmodule

@@ files.f @@
hdl/wsmd_pkg.sv
hdl/wsmd_ctrl.sv
hdl/wsmd_dp.sv
hdl/wav_stream_mono_decoder_unit.sv
tb/sv/testbench.sv
